>>> src/ric_pkg.sv
package ric_pkg;

    // Pipeline layout: stage 0 holds the products and the last stage is the output register.
    localparam int NUM_STAGES    = 25;
    localparam int ST_SUM        = 1;
    localparam int ST_SQRT_FIRST = 2;
    localparam int ST_SQRT_LAST  = 13;
    localparam int ST_LDIV_LAST  = 9;
    localparam int ST_DIV_INIT   = 14;
    localparam int ST_DIV_LAST   = 22;
    localparam int ST_RATE       = 23;
    localparam int ST_CLASS      = 24;

    // Confidence constants in Q1.15.
    localparam logic [15:0] CONF_ONE   = 16'd32768;
    localparam logic [15:0] CONF_ORBIT = 16'd22938;

    // Reciprocal of three scaled by 2^25, exact for dividends below 2^23.
    localparam logic [23:0] RECIP_THREE = 24'd11184811;

    typedef enum logic [2:0] {
        INTENT_UNKNOWN  = 3'd0,
        INTENT_APPROACH = 3'd1,
        INTENT_DEPART   = 3'd2,
        INTENT_ORBIT    = 3'd3,
        INTENT_LOITER   = 3'd4,
        INTENT_TRANSIT  = 3'd5
    } intent_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_EPSILON     = 3'd0,
        REG_APPROACH_THRESHOLD = 3'd1,
        REG_DEPART_THRESHOLD   = 3'd2,
        REG_ORBIT_SPEED_MIN    = 3'd3,
        REG_ORBIT_RADIUS_MIN   = 3'd4,
        REG_ORBIT_RADIUS_MAX   = 3'd5,
        REG_LOITER_SPEED_MAX   = 3'd6,
        REG_TRANSIT_SPEED_MIN  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [15:0]        origin_epsilon;
        logic signed [16:0] approach_threshold;
        logic signed [16:0] depart_threshold;
        logic [15:0]        orbit_speed_min;
        logic [23:0]        orbit_radius_min;
        logic [23:0]        orbit_radius_max;
        logic [15:0]        loiter_speed_max;
        logic [15:0]        transit_speed_min;
    } cfg_t;

    // One track as it moves down the pipeline.
    typedef struct packed {
        logic [15:0]        spd;
        logic [46:0]        pxx;
        logic [46:0]        pyy;
        logic signed [39:0] pxvx;
        logic signed [39:0] pyvy;
        logic [46:0]        tprod;
        logic [15:0]        tconf;
        logic [47:0]        dsq;
        logic [26:0]        sq_rem;
        logic [23:0]        root;
        logic [39:0]        mag;
        logic               dneg;
        logic               sat;
        logic [24:0]        drem;
        logic [16:0]        quo;
        logic [16:0]        lrem;
        logic [15:0]        lsh;
        logic [15:0]        lq;
        logic signed [16:0] rate;
        logic               near;
        intent_t            code;
        logic [15:0]        conf;
        logic [23:0]        radius;
        logic signed [16:0] crate;
    } trk_t;

    // Work done by pipeline stage k on the word coming from stage k-1.
    function automatic trk_t trk_step(input int k, input trk_t d, input cfg_t c);
        trk_t               q;
        logic signed [40:0] dot;
        logic [26:0]        trial_rem;
        logic [25:0]        trial;
        logic [16:0]        lnext;
        logic [24:0]        dnext;
        logic [21:0]        tq;
        logic [16:0]        nrate;
        q = d;

        // Sums, magnitude of the dot product, the transit confidence and the loiter division setup.
        if (k == ST_SUM) begin
            q.dsq    = {1'b0, d.pxx} + {1'b0, d.pyy};
            dot      = 41'(d.pxvx) + 41'(d.pyvy);
            q.dneg   = dot[40];
            q.mag    = dot[40] ? 40'(-dot) : dot[39:0];
            tq       = d.tprod[46:25];
            q.tconf  = (tq > 22'(CONF_ONE)) ? CONF_ONE : tq[15:0];
            q.sq_rem = '0;
            q.root   = '0;
            q.lrem   = {2'b00, d.spd[15:1]};
            q.lsh    = {d.spd[0], 15'b0};
            q.lq     = '0;
        end

        // Square root, two digits per stage; loiter division shares the early stages.
        if (k >= ST_SQRT_FIRST && k <= ST_SQRT_LAST) begin
            for (int j = 0; j < 2; j++) begin
                trial_rem = {q.sq_rem[24:0], q.dsq[47:46]};
                q.dsq     = {q.dsq[45:0], 2'b00};
                trial     = {q.root, 2'b01};
                if (trial_rem >= {1'b0, trial}) begin
                    q.sq_rem = trial_rem - {1'b0, trial};
                    q.root   = {q.root[22:0], 1'b1};
                end else begin
                    q.sq_rem = trial_rem;
                    q.root   = {q.root[22:0], 1'b0};
                end
            end
            if (k <= ST_LDIV_LAST) begin
                for (int j = 0; j < 2; j++) begin
                    lnext = {q.lrem[15:0], q.lsh[15]};
                    q.lsh = {q.lsh[14:0], 1'b0};
                    if (lnext >= {1'b0, c.loiter_speed_max}) begin
                        q.lrem = lnext - {1'b0, c.loiter_speed_max};
                        q.lq   = {q.lq[14:0], 1'b1};
                    end else begin
                        q.lrem = lnext;
                        q.lq   = {q.lq[14:0], 1'b0};
                    end
                end
            end
        end

        // Closing rate division: overflow check and the first quotient bit, then the rest in later stages.
        if (k == ST_DIV_INIT) begin
            q.sat  = ({1'b0, d.mag[39:17]} >= d.root);
            q.drem = {2'b00, d.mag[39:17]};
            q.quo  = '0;
        end
        if (k >= ST_DIV_INIT && k <= ST_DIV_LAST) begin
            for (int j = 0; j < 2; j++) begin
                if (k != ST_DIV_INIT || j == 0) begin
                    dnext = {q.drem[23:0], q.mag[16]};
                    q.mag = {q.mag[38:0], 1'b0};
                    if (dnext >= {1'b0, q.root}) begin
                        q.drem = dnext - {1'b0, q.root};
                        q.quo  = {q.quo[15:0], 1'b1};
                    end else begin
                        q.drem = dnext;
                        q.quo  = {q.quo[15:0], 1'b0};
                    end
                end
            end
        end

        // Signed, saturated rate and the near-origin test.
        if (k == ST_RATE) begin
            if (d.dneg) begin
                q.rate = (d.sat || d.quo[16]) ? 17'sd65535 : signed'({1'b0, d.quo[15:0]});
            end else if (d.sat || d.quo > 17'd65536) begin
                q.rate = signed'(17'h10000);
            end else begin
                q.rate = signed'(~d.quo + 17'd1);
            end
            q.near = (d.root == 24'd0) || (d.root < {8'b0, c.origin_epsilon});
        end

        // Prioritized classification.
        if (k == ST_CLASS) begin
            q.code   = INTENT_UNKNOWN;
            q.conf   = '0;
            q.radius = '0;
            q.crate  = '0;
            nrate    = ~d.rate + 17'd1;
            if (d.near) begin
                q.code = INTENT_UNKNOWN;
            end else if (d.rate > c.approach_threshold) begin
                q.code  = INTENT_APPROACH;
                q.crate = d.rate;
                if (d.rate <= 17'sd0) begin
                    q.conf = '0;
                end else if (d.rate >= 17'sd512) begin
                    q.conf = CONF_ONE;
                end else begin
                    q.conf = {d.rate[9:0], 6'b0};
                end
            end else if (d.rate < c.depart_threshold) begin
                q.code = INTENT_DEPART;
                if (d.rate >= 17'sd0) begin
                    q.conf = '0;
                end else if (d.rate <= -17'sd512) begin
                    q.conf = CONF_ONE;
                end else begin
                    q.conf = {nrate[9:0], 6'b0};
                end
            end else if (d.spd >= c.orbit_speed_min && d.root >= c.orbit_radius_min &&
                         d.root <= c.orbit_radius_max) begin
                q.code   = INTENT_ORBIT;
                q.conf   = CONF_ORBIT;
                q.radius = d.root;
            end else if (d.spd <= c.loiter_speed_max) begin
                q.code   = INTENT_LOITER;
                q.radius = d.root;
                q.conf   = (c.loiter_speed_max == 16'd0) ? CONF_ONE : CONF_ONE - d.lq;
            end else if (d.spd >= c.transit_speed_min) begin
                q.code = INTENT_TRANSIT;
                q.conf = d.tconf;
            end
        end
        return q;
    endfunction

endpackage

>>> src/radial_intent_classifier_core.sv
// Track intent classifier. Each accepted word is one track; one result word comes out per
// track, in order. The block takes a new word every cycle while the pipeline has room. The
// depth of the pipeline is set by the 24-digit square root for the range followed by the
// 17-bit closing rate division, both laid out two steps per pipeline stage, but for the
// first division stage, which takes one. Bubbles between stages are squeezed out, so a
// stalled output does not block input until the pipeline is full.
// Configuration registers may only be written while no track is in flight.
module radial_intent_classifier_core (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: pos_x[23:0], pos_y[47:24], vel_x[63:48], vel_y[79:64], ground_speed[95:80]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,
    // m_tdata: intent_code[2:0], confidence[18:3], loiter_radius[42:19],
    //          closing_rate[59:43], zero[63:60]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int LAST = ric_pkg::NUM_STAGES - 1;

    ric_pkg::cfg_t cfg_reg;
    ric_pkg::trk_t trk_reg   [ric_pkg::NUM_STAGES];
    logic          valid_reg [ric_pkg::NUM_STAGES];
    logic          rdy       [ric_pkg::NUM_STAGES];
    ric_pkg::trk_t stage0_next;

    // Configuration register file.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_epsilon     <= 16'd1;
            cfg_reg.approach_threshold <= 17'sd128;
            cfg_reg.depart_threshold   <= -17'sd128;
            cfg_reg.orbit_speed_min    <= 16'd256;
            cfg_reg.orbit_radius_min   <= 24'd1280;
            cfg_reg.orbit_radius_max   <= 24'd51200;
            cfg_reg.loiter_speed_max   <= 16'd128;
            cfg_reg.transit_speed_min  <= 16'd384;
        end else if (cfg_valid && cfg_ready) begin
            case (ric_pkg::cfg_index_t'(cfg_index))
                ric_pkg::REG_ORIGIN_EPSILON:     cfg_reg.origin_epsilon     <= cfg_data[15:0];
                ric_pkg::REG_APPROACH_THRESHOLD: cfg_reg.approach_threshold <= signed'(cfg_data[16:0]);
                ric_pkg::REG_DEPART_THRESHOLD:   cfg_reg.depart_threshold   <= signed'(cfg_data[16:0]);
                ric_pkg::REG_ORBIT_SPEED_MIN:    cfg_reg.orbit_speed_min    <= cfg_data[15:0];
                ric_pkg::REG_ORBIT_RADIUS_MIN:   cfg_reg.orbit_radius_min   <= cfg_data;
                ric_pkg::REG_ORBIT_RADIUS_MAX:   cfg_reg.orbit_radius_max   <= cfg_data;
                ric_pkg::REG_LOITER_SPEED_MAX:   cfg_reg.loiter_speed_max   <= cfg_data[15:0];
                ric_pkg::REG_TRANSIT_SPEED_MIN:  cfg_reg.transit_speed_min  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Stage 0 work: the products that feed the squared range, the dot product and transit.
    always_comb begin
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [47:0] sq_x;
        logic signed [47:0] sq_y;
        px = signed'(s_tdata[23:0]);
        py = signed'(s_tdata[47:24]);
        vx = signed'(s_tdata[63:48]);
        vy = signed'(s_tdata[79:64]);
        sq_x = px * px;
        sq_y = py * py;
        stage0_next       = '0;
        stage0_next.spd   = s_tdata[95:80];
        stage0_next.pxx   = sq_x[46:0];
        stage0_next.pyy   = sq_y[46:0];
        stage0_next.pxvx  = 40'(px * vx);
        stage0_next.pyvy  = 40'(py * vy);
        stage0_next.tprod = {s_tdata[95:80], 7'b0} * ric_pkg::RECIP_THREE;
    end

    // Ready flows backward; a stage may load when it is empty or its word moves on.
    always_comb begin
        rdy[LAST] = !valid_reg[LAST] || m_tready;
        for (int i = LAST - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i + 1];
        end
    end

    assign s_tready = rdy[0];

    // Pipeline registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            valid_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && s_tvalid) begin
            trk_reg[0] <= stage0_next;
        end
    end

    for (genvar g = 1; g < ric_pkg::NUM_STAGES; g++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (rdy[g]) begin
                valid_reg[g] <= valid_reg[g - 1];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[g] && valid_reg[g - 1]) begin
                trk_reg[g] <= ric_pkg::trk_step(g, trk_reg[g - 1], cfg_reg);
            end
        end
    end

    // Result word.
    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = {4'b0000, trk_reg[LAST].crate, trk_reg[LAST].radius,
                       trk_reg[LAST].conf, trk_reg[LAST].code};

    // Input stalls only when every stage is full and the output is held.
    a_stall_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (valid_reg[LAST] && !m_tready))
        else $error("input stalled while the pipeline had room");

    // The closing rate is reported for approaching tracks only.
    a_rate_only_approach : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] != ric_pkg::INTENT_APPROACH) |-> (m_tdata[59:43] == 17'd0))
        else $error("closing rate on a track that is not approaching");

    // Unknown tracks carry no confidence and no radius.
    a_unknown_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == ric_pkg::INTENT_UNKNOWN) |->
            (m_tdata[18:3] == 16'd0 && m_tdata[42:19] == 24'd0))
        else $error("unknown track with nonzero confidence or radius");

    // Confidence never exceeds one.
    a_conf_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:3] <= ric_pkg::CONF_ONE))
        else $error("confidence above one");

endmodule

>>> verif/tb_radial_intent_classifier_core.sv
`timescale 1ns / 1ps

module tb_radial_intent_classifier_core;

    localparam int PIPE_DEPTH  = ric_pkg::NUM_STAGES;
    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = PIPE_DEPTH + 8;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [15:0]        ground_speed;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_x;
    } track_t;

    typedef struct packed {
        logic signed [16:0] closing_rate;
        logic [23:0]        loiter_radius;
        logic [15:0]        confidence;
        ric_pkg::intent_t   intent_code;
    } intent_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    // Model copy of the thresholds and the results still owed by the block.
    ric_pkg::cfg_t  thresholds;
    intent_result_t expected_intents[$];
    int             mismatch_count = 0;
    int             tracks_sent = 0;
    int             results_seen = 0;
    int             class_hits[6];
    bit             steady = 1'b0;
    int             hold_request = 0;

    radial_intent_classifier_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Integer square root of the squared distance, one result bit at a time.
    function automatic longint unsigned range_root(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitpos;
        res = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > n) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (n >= res + bitpos) begin
                n = n - (res + bitpos);
                res = (res >> 1) + bitpos;
            end else begin
                res = res >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_unit(input longint c);
        if (c < 0) return 0;
        if (c > 32768) return 32768;
        return c;
    endfunction

    // Classify one track against the current thresholds.
    function automatic intent_result_t classify_track(input track_t t);
        intent_result_t  r;
        longint          px, py, vx, vy, spd, dot, rate, q;
        longint unsigned range_q8;
        longint unsigned mag;
        px = t.pos_x;
        py = t.pos_y;
        vx = t.vel_x;
        vy = t.vel_y;
        spd = t.ground_speed;
        r = '0;
        r.intent_code = ric_pkg::INTENT_UNKNOWN;
        range_q8 = range_root(longint'(px * px + py * py));
        if (range_q8 != 0 && range_q8 >= thresholds.origin_epsilon) begin
            dot = px * vx + py * vy;
            mag = (dot < 0 ? -dot : dot) / range_q8;
            rate = (dot < 0) ? longint'(mag) : -longint'(mag);
            if (rate > 65535) rate = 65535;
            if (rate < -65536) rate = -65536;
            if (rate > longint'(thresholds.approach_threshold)) begin
                r.intent_code = ric_pkg::INTENT_APPROACH;
                r.confidence = 16'(clamp_unit(rate * 64));
                r.closing_rate = 17'(rate);
            end else if (rate < longint'(thresholds.depart_threshold)) begin
                r.intent_code = ric_pkg::INTENT_DEPART;
                r.confidence = 16'(clamp_unit(-rate * 64));
            end else if (spd >= thresholds.orbit_speed_min &&
                         range_q8 >= thresholds.orbit_radius_min &&
                         range_q8 <= thresholds.orbit_radius_max) begin
                r.intent_code = ric_pkg::INTENT_ORBIT;
                r.confidence = ric_pkg::CONF_ORBIT;
                r.loiter_radius = 24'(range_q8);
            end else if (spd <= thresholds.loiter_speed_max) begin
                q = 0;
                if (thresholds.loiter_speed_max != 0)
                    q = (spd * 32768) / thresholds.loiter_speed_max;
                r.intent_code = ric_pkg::INTENT_LOITER;
                r.loiter_radius = 24'(range_q8);
                r.confidence = 16'(clamp_unit(32768 - q));
            end else if (spd >= thresholds.transit_speed_min) begin
                r.intent_code = ric_pkg::INTENT_TRANSIT;
                r.confidence = 16'(clamp_unit((spd * 128) / 3));
            end
        end
        return r;
    endfunction

    // Offer one track word, wait for acceptance, then, for a nonzero gap, drop valid and idle.
    task automatic send_track(input track_t t, input int gap);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        do @(posedge aclk); while (!s_tready);
        expected_intents.push_back(classify_track(t));
        tracks_sent++;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Wait until every result has come back and the pipeline is empty.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_intents.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_threshold(input ric_pkg::cfg_index_t idx, input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[23:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            ric_pkg::REG_ORIGIN_EPSILON:     thresholds.origin_epsilon     = value[15:0];
            ric_pkg::REG_APPROACH_THRESHOLD: thresholds.approach_threshold = value[16:0];
            ric_pkg::REG_DEPART_THRESHOLD:   thresholds.depart_threshold   = value[16:0];
            ric_pkg::REG_ORBIT_SPEED_MIN:    thresholds.orbit_speed_min    = value[15:0];
            ric_pkg::REG_ORBIT_RADIUS_MIN:   thresholds.orbit_radius_min   = value[23:0];
            ric_pkg::REG_ORBIT_RADIUS_MAX:   thresholds.orbit_radius_max   = value[23:0];
            ric_pkg::REG_LOITER_SPEED_MAX:   thresholds.loiter_speed_max   = value[15:0];
            ric_pkg::REG_TRANSIT_SPEED_MIN:  thresholds.transit_speed_min  = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_thresholds(input int eps, input int appr, input int dep,
                                   input int osmin, input int rmin, input int rmax,
                                   input int lsmax, input int tsmin);
        write_threshold(ric_pkg::REG_ORIGIN_EPSILON, eps);
        write_threshold(ric_pkg::REG_APPROACH_THRESHOLD, appr);
        write_threshold(ric_pkg::REG_DEPART_THRESHOLD, dep);
        write_threshold(ric_pkg::REG_ORBIT_SPEED_MIN, osmin);
        write_threshold(ric_pkg::REG_ORBIT_RADIUS_MIN, rmin);
        write_threshold(ric_pkg::REG_ORBIT_RADIUS_MAX, rmax);
        write_threshold(ric_pkg::REG_LOITER_SPEED_MAX, lsmax);
        write_threshold(ric_pkg::REG_TRANSIT_SPEED_MIN, tsmin);
    endtask

    function automatic track_t make_track(input int px, input int py, input int vx,
                                          input int vy, input int spd);
        track_t t;
        t.pos_x = 24'(px);
        t.pos_y = 24'(py);
        t.vel_x = 16'(vx);
        t.vel_y = 16'(vy);
        t.ground_speed = 16'(spd);
        return t;
    endfunction

    // Random track: positions at a random scale so every range band is visited.
    function automatic track_t random_track();
        track_t t;
        int     roll;
        roll = $urandom_range(0, 9);
        t.pos_x = 24'($urandom());
        t.pos_y = 24'($urandom());
        t.vel_x = 16'($urandom());
        t.vel_y = 16'($urandom());
        t.ground_speed = 16'($urandom());
        if (roll < 7) begin
            t.pos_x = t.pos_x >>> $urandom_range(0, 23);
            t.pos_y = t.pos_y >>> $urandom_range(0, 23);
            t.vel_x = t.vel_x >>> $urandom_range(0, 15);
            t.vel_y = t.vel_y >>> $urandom_range(0, 15);
            t.ground_speed = t.ground_speed >> $urandom_range(4, 15);
        end
        if (roll == 7) begin
            // Velocity normal to the unshifted position; tangential when both shifts match.
            t.vel_x = 16'(-(t.pos_y >>> 10));
            t.vel_y = 16'(t.pos_x >>> 10);
            t.pos_x = t.pos_x >>> $urandom_range(4, 10);
            t.pos_y = t.pos_y >>> $urandom_range(4, 10);
            t.ground_speed = 16'($urandom_range(0, 600));
        end
        return t;
    endfunction

    task automatic send_random_tracks(input int count);
        for (int i = 0; i < count; i++) send_track(random_track(), pick_gap());
    endtask

    // Receiver: random stalls, plus long hold-offs on request.
    always @(negedge aclk) begin
        static int stall_left = 0;
        int roll;
        if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 8) stall_left = $urandom_range(1, 3);
            else if (roll < 10) stall_left = $urandom_range(10, 40);
            m_tready <= (stall_left == 0);
        end
    end

    // Compare each result word with the oldest expectation.
    always @(posedge aclk) begin
        intent_result_t want;
        intent_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[59:0];
            results_seen++;
            if (expected_intents.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %h", m_tdata);
            end else begin
                want = expected_intents.pop_front();
                class_hits[want.intent_code]++;
                if (got !== want || m_tdata[63:60] !== 4'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: expected code %0d conf %0d radius %0d rate %0d,%s",
                                 results_seen, want.intent_code, want.confidence,
                                 want.loiter_radius, want.closing_rate,
                                 $sformatf(" got code %0d conf %0d radius %0d rate %0d",
                                           got.intent_code, got.confidence,
                                           got.loiter_radius, got.closing_rate));
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge aclk) begin
        static int quiet_cycles = 0;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("radial_intent_classifier_core: mismatch");
            $finish;
        end
    end

    // Every branch of the chain and the field extremes at reset thresholds.
    task automatic test_directed_tracks();
        send_track(make_track(0, 0, 32767, -32768, 65535), 0);             // at the origin
        send_track(make_track(-8388608, -8388608, -32768, -32768, 0), 1);  // far, opening max
        send_track(make_track(8388607, 8388607, 32767, 32767, 65535), 0);  // far, opening max
        send_track(make_track(8388607, -8388608, 0, 0, 65535), 0);
        send_track(make_track(5120, 0, -512, 0, 100), 0);                  // approaching
        send_track(make_track(5120, 0, 100, 0, 100), 0);                   // opening, loiter
        send_track(make_track(5120, 0, 512, 0, 100), 2);                   // departing
        send_track(make_track(5120, 0, 0, 300, 300), 0);                   // orbiting
        send_track(make_track(1280, 0, 0, 256, 256), 0);                   // orbit band floor
        send_track(make_track(51200, 0, 0, 256, 256), 0);                  // orbit band ceiling
        send_track(make_track(51201, 0, 0, 256, 256), 0);
        send_track(make_track(100000, 0, 0, 0, 0), 0);                     // loiter, still
        send_track(make_track(100000, 0, 0, 0, 128), 0);                   // loiter limit
        send_track(make_track(100000, 0, 0, 0, 64), 0);
        send_track(make_track(100000, 0, 0, 0, 384), 0);                   // transit
        send_track(make_track(100000, 0, 0, 0, 65535), 0);                 // transit, clamped
        send_track(make_track(100000, 0, 0, 0, 200), 0);                   // nothing matches
        send_track(make_track(1, 0, -32768, 0, 0), 0);                     // tiny range
        send_track(make_track(0, -1, 0, 32767, 0), 0);
        send_track(make_track(3, 4, -1, -1, 1), 0);
        drain_pipeline();
    endtask

    // Random tracks under a few threshold sets, extremes among them.
    task automatic test_threshold_sweep();
        load_thresholds(0, -65536, 65535, 0, 16777215, 0, 0, 0);
        send_random_tracks(120);
        drain_pipeline();
        load_thresholds(65535, 65535, -65536, 65535, 0, 16777215, 65535, 65535);
        send_random_tracks(120);
        drain_pipeline();
        load_thresholds(0, 0, 0, 0, 0, 16777215, 0, 65535);
        send_track(make_track(0, 0, 5, 5, 0), 0);
        send_track(make_track(256, 0, 0, 0, 0), 0);
        send_random_tracks(100);
        drain_pipeline();
        for (int phase = 0; phase < 3; phase++) begin
            load_thresholds($urandom_range(0, 300), $urandom_range(0, 1024) - 512,
                            $urandom_range(0, 1024) - 512, $urandom_range(0, 800),
                            $urandom_range(0, 20000), $urandom_range(10000, 2000000),
                            $urandom_range(1, 2000), $urandom_range(0, 3000));
            send_random_tracks(130);
            drain_pipeline();
        end
        load_thresholds(1, 128, -128, 256, 1280, 51200, 128, 384);
    endtask

    // Long receiver hold-off at full sender rate, a burst with no idling, then random traffic.
    task automatic test_output_backpressure();
        hold_request = LONG_HOLD;
        steady = 1'b1;
        send_random_tracks(60);
        drain_pipeline();
        send_random_tracks(60);
        steady = 1'b0;
        drain_pipeline();
        send_random_tracks(100);
        drain_pipeline();
    endtask

    initial begin
        thresholds = '0;
        thresholds.origin_epsilon     = 16'd1;
        thresholds.approach_threshold = 17'sd128;
        thresholds.depart_threshold   = -17'sd128;
        thresholds.orbit_speed_min    = 16'd256;
        thresholds.orbit_radius_min   = 24'd1280;
        thresholds.orbit_radius_max   = 24'd51200;
        thresholds.loiter_speed_max   = 16'd128;
        thresholds.transit_speed_min  = 16'd384;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_tracks();
        test_threshold_sweep();
        test_output_backpressure();
        $display("Sent %0d tracks under several threshold sets with random stalls on both sides.",
                 tracks_sent);
        $display("Classes seen: unknown %0d, approach %0d, depart %0d, orbit %0d, %s",
                 class_hits[0], class_hits[1], class_hits[2], class_hits[3],
                 $sformatf("loiter %0d, transit %0d", class_hits[4], class_hits[5]));
        if (mismatch_count == 0 && expected_intents.size() == 0)
            $display("radial_intent_classifier_core: match");
        else
            $display("radial_intent_classifier_core: mismatch");
        $finish;
    end

endmodule
